// ===== rtl/core/stjd_pkg.sv =====
`timescale 1ns / 1ps

package stjd_pkg;

    // widths of the working remainder and of the shared subtractor operand
    localparam int unsigned REM_W = 34;
    localparam int unsigned QUO_W = 17;
    localparam int unsigned YEAR_W = 11;
    localparam int unsigned CFG_DATA_W = 18;

    typedef logic [REM_W-1:0] rem_t;
    typedef logic [YEAR_W-1:0] year_t;

    // configuration register indexes
    localparam logic CFG_LOCAL_OFFSET = 1'b0;
    localparam logic CFG_SUMMER_SHIFT = 1'b1;

    localparam logic [17:0] LOCAL_OFFSET_RST = 18'd16200;
    localparam logic [12:0] SUMMER_SHIFT_RST = 13'd3600;

    localparam rem_t SECS_PER_DAY = 34'd86400;
    localparam rem_t SECS_PER_HOUR = 34'd3600;
    localparam rem_t SECS_PER_MIN = 34'd60;
    localparam rem_t DAYS_PER_WEEK = 34'd7;
    localparam rem_t WEEKDAY_BIAS = 34'd6;
    localparam rem_t EPOCH_REM_SECS = 34'd24710400;
    localparam rem_t YEAR_COMMON_SECS = 34'd31536000;
    localparam rem_t YEAR_LEAP_SECS = 34'd31622400;
    localparam rem_t MONTH31_SECS = 34'd2678400;
    localparam rem_t MONTH30_SECS = 34'd2592000;

    localparam year_t YEAR_LIMIT = 11'd1498;

    localparam int unsigned LEAP_COUNT = 71;
    localparam year_t LEAP_YEARS [0:LEAP_COUNT-1] = '{
        11'd1210, 11'd1214, 11'd1218, 11'd1222, 11'd1226, 11'd1230, 11'd1234, 11'd1238,
        11'd1243, 11'd1247, 11'd1251, 11'd1255, 11'd1259, 11'd1263, 11'd1267, 11'd1271,
        11'd1276, 11'd1280, 11'd1284, 11'd1288, 11'd1292, 11'd1296, 11'd1300, 11'd1304,
        11'd1309, 11'd1313, 11'd1317, 11'd1321, 11'd1325, 11'd1329, 11'd1333, 11'd1337,
        11'd1342, 11'd1346, 11'd1350, 11'd1354, 11'd1358, 11'd1362, 11'd1366, 11'd1370,
        11'd1375, 11'd1379, 11'd1383, 11'd1387, 11'd1391, 11'd1395, 11'd1399, 11'd1403,
        11'd1408, 11'd1412, 11'd1416, 11'd1420, 11'd1424, 11'd1428, 11'd1432, 11'd1436,
        11'd1441, 11'd1445, 11'd1449, 11'd1453, 11'd1457, 11'd1461, 11'd1465, 11'd1469,
        11'd1474, 11'd1478, 11'd1482, 11'd1486, 11'd1490, 11'd1494, 11'd1498
    };

    // leap year lookup against the fixed table
    function automatic logic is_leap(input year_t yr);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < LEAP_COUNT; k++)
        begin
            if (LEAP_YEARS[k] == yr)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== rtl/core/seconds_to_jalali_date_top.sv =====
`timescale 1ns / 1ps

// unix second count to jalali calendar date. pulse start while busy is low to
// launch one transaction on unix_time; busy stays high until the result is
// shown, and done is high for exactly one cycle with year, month_index,
// day_of_month, hour, minute, sec, weekday and out_of_range valid in that
// cycle (the receiver cannot stall, so capture on done). done rises as busy
// drops. the year walk covers at most 150 whole years from EPOCH_YEAR inside
// the table. a date past the table comes back with out_of_range set and only
// the weekday meaningful. all of it runs through one 35-bit subtract-and-
// compare unit: 17 steps of division by a day for the weekday, 15 steps of
// modulo 7, one step per year plus one to stop, the month walk, then 5 + 5 +
// 6 steps to split the day into day, hour and minute. configuration
// (cfg_index 0 local_offset, 1 summer_shift) is written with cfg_we; the user
// must write it only while idle, as the block itself does not enforce this,
// and a write made while idle takes effect from the next transaction.
module seconds_to_jalali_date_top
    import stjd_pkg::*;
#(
    parameter int unsigned EPOCH_YEAR = 1348
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // command side
    input  logic                  start,
    output logic                  busy,
    input  logic [32:0]           unix_time,
    // result side
    output logic                  done,
    output logic [10:0]           year,
    output logic [3:0]            month_index,
    output logic [4:0]            day_of_month,
    output logic [4:0]            hour,
    output logic [5:0]            minute,
    output logic [5:0]            sec,
    output logic [2:0]            weekday,
    output logic                  out_of_range
);

    localparam year_t EPOCH_YR = YEAR_W'(EPOCH_YEAR);

    // sequencer phases
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVD,   // local seconds / day, quotient kept for the weekday
        S_MOD7,   // day count + 6 mod 7
        S_YEAR,   // whole years from the epoch
        S_M31,    // first five 31-day months
        S_CHK,    // at Shahrivar: is summer time over
        S_SUM,    // remove the summer shift
        S_M5,     // step over Shahrivar
        S_M30,    // 30-day months up to Esfand
        S_DAY,    // day of month
        S_HR,     // hour
        S_MIN     // minute and second
    } state_t;

    state_t            state_reg, state_next;
    rem_t              rem_reg, rem_next;
    rem_t              save_reg, save_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [4:0]        step_reg, step_next;
    year_t             yr_reg, yr_next;
    logic [3:0]        mon_reg, mon_next;
    logic [2:0]        wd_reg, wd_next;
    logic [4:0]        day_reg, day_next;
    logic [4:0]        hr_reg, hr_next;

    logic [17:0]       local_offset_reg, local_offset_next;
    logic [12:0]       summer_shift_reg, summer_shift_next;

    // result registers
    logic              done_reg, done_next;
    year_t             year_reg, year_next;
    logic [3:0]        month_reg, month_next;
    logic [4:0]        dom_reg, dom_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        minute_reg, minute_next;
    logic [5:0]        sec_reg, sec_next;
    logic [2:0]        weekday_reg, weekday_next;
    logic              oor_reg, oor_next;

    // shared subtract-and-compare unit
    rem_t              operand;
    logic [REM_W:0]    diff;
    logic              ge;
    rem_t              rem_sub;
    logic [QUO_W-1:0]  quo_shift;
    rem_t              rem_load;

    // local seconds counted from the start of the epoch year
    assign rem_load = REM_W'(unix_time)
                    + {{(REM_W-18){local_offset_reg[17]}}, local_offset_reg}
                    + EPOCH_REM_SECS;

    always_comb
    begin
        unique case (state_reg)
            S_DIVD:        operand = SECS_PER_DAY << step_reg;
            S_MOD7:        operand = DAYS_PER_WEEK << step_reg;
            S_YEAR:        operand = is_leap(yr_reg) ? YEAR_LEAP_SECS : YEAR_COMMON_SECS;
            S_M31, S_M5:   operand = MONTH31_SECS;
            S_CHK, S_M30:  operand = MONTH30_SECS;
            S_SUM:         operand = REM_W'(summer_shift_reg);
            S_DAY:         operand = SECS_PER_DAY << step_reg;
            S_HR:          operand = SECS_PER_HOUR << step_reg;
            S_MIN:         operand = SECS_PER_MIN << step_reg;
            default:       operand = '0;
        endcase
    end

    assign diff      = {1'b0, rem_reg} - {1'b0, operand};
    assign ge        = ~diff[REM_W];
    assign rem_sub   = ge ? diff[REM_W-1:0] : rem_reg;
    assign quo_shift = {quo_reg[QUO_W-2:0], ge};

    always_comb
    begin
        state_next        = state_reg;
        rem_next          = rem_reg;
        save_next         = save_reg;
        quo_next          = quo_reg;
        step_next         = step_reg;
        yr_next           = yr_reg;
        mon_next          = mon_reg;
        wd_next           = wd_reg;
        day_next          = day_reg;
        hr_next           = hr_reg;
        local_offset_next = local_offset_reg;
        summer_shift_next = summer_shift_reg;
        done_next         = 1'b0;
        year_next         = year_reg;
        month_next        = month_reg;
        dom_next          = dom_reg;
        hour_next         = hour_reg;
        minute_next       = minute_reg;
        sec_next          = sec_reg;
        weekday_next      = weekday_reg;
        oor_next          = oor_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOCAL_OFFSET: local_offset_next = cfg_data;
                CFG_SUMMER_SHIFT: summer_shift_next = cfg_data[12:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rem_next   = rem_load;
                    save_next  = rem_load;
                    quo_next   = '0;
                    step_next  = 5'(QUO_W - 1);
                    yr_next    = EPOCH_YR;
                    mon_next   = '0;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                rem_next  = rem_sub;
                quo_next  = quo_shift;
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                begin
                    // day count plus bias goes straight on to the modulo
                    rem_next   = REM_W'(quo_shift) + WEEKDAY_BIAS;
                    step_next  = 5'd14;
                    state_next = S_MOD7;
                end
            end
            S_MOD7:
            begin
                rem_next  = rem_sub;
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                begin
                    wd_next    = rem_sub[2:0];
                    rem_next   = save_reg;
                    state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (yr_reg > YEAR_LIMIT)
                begin
                    // beyond the table: only the weekday is meaningful
                    year_next    = '0;
                    month_next   = '0;
                    dom_next     = '0;
                    hour_next    = '0;
                    minute_next  = '0;
                    sec_next     = '0;
                    weekday_next = wd_reg;
                    oor_next     = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (ge)
                begin
                    rem_next = diff[REM_W-1:0];
                    yr_next  = yr_reg + 11'd1;
                end
                else
                begin
                    state_next = S_M31;
                end
            end
            S_M31:
            begin
                if (mon_reg < 4'd5)
                begin
                    if (ge)
                    begin
                        rem_next = diff[REM_W-1:0];
                        mon_next = mon_reg + 4'd1;
                    end
                    else
                    begin
                        quo_next   = '0;
                        step_next  = 5'd4;
                        state_next = S_DAY;
                    end
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = ge ? S_SUM : S_M5;
            end
            S_SUM:
            begin
                rem_next   = diff[REM_W-1:0];
                state_next = S_M5;
            end
            S_M5:
            begin
                if (ge)
                begin
                    rem_next   = diff[REM_W-1:0];
                    mon_next   = 4'd6;
                    state_next = S_M30;
                end
                else
                begin
                    quo_next   = '0;
                    step_next  = 5'd4;
                    state_next = S_DAY;
                end
            end
            S_M30:
            begin
                if (mon_reg < 4'd11 && ge)
                begin
                    rem_next = diff[REM_W-1:0];
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    quo_next   = '0;
                    step_next  = 5'd4;
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                rem_next  = rem_sub;
                quo_next  = quo_shift;
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                begin
                    day_next   = quo_shift[4:0];
                    quo_next   = '0;
                    step_next  = 5'd4;
                    state_next = S_HR;
                end
            end
            S_HR:
            begin
                rem_next  = rem_sub;
                quo_next  = quo_shift;
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                begin
                    hr_next    = quo_shift[4:0];
                    quo_next   = '0;
                    step_next  = 5'd5;
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                rem_next  = rem_sub;
                quo_next  = quo_shift;
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                begin
                    year_next    = yr_reg;
                    month_next   = mon_reg;
                    dom_next     = day_reg + 5'd1;
                    hour_next    = hr_reg;
                    minute_next  = quo_shift[5:0];
                    sec_next     = rem_sub[5:0];
                    weekday_next = wd_reg;
                    oor_next     = 1'b0;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rem_reg          <= '0;
            save_reg         <= '0;
            quo_reg          <= '0;
            step_reg         <= '0;
            yr_reg           <= EPOCH_YR;
            mon_reg          <= '0;
            wd_reg           <= '0;
            day_reg          <= '0;
            hr_reg           <= '0;
            local_offset_reg <= LOCAL_OFFSET_RST;
            summer_shift_reg <= SUMMER_SHIFT_RST;
            done_reg         <= 1'b0;
            year_reg         <= '0;
            month_reg        <= '0;
            dom_reg          <= '0;
            hour_reg         <= '0;
            minute_reg       <= '0;
            sec_reg          <= '0;
            weekday_reg      <= '0;
            oor_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rem_reg          <= rem_next;
            save_reg         <= save_next;
            quo_reg          <= quo_next;
            step_reg         <= step_next;
            yr_reg           <= yr_next;
            mon_reg          <= mon_next;
            wd_reg           <= wd_next;
            day_reg          <= day_next;
            hr_reg           <= hr_next;
            local_offset_reg <= local_offset_next;
            summer_shift_reg <= summer_shift_next;
            done_reg         <= done_next;
            year_reg         <= year_next;
            month_reg        <= month_next;
            dom_reg          <= dom_next;
            hour_reg         <= hour_next;
            minute_reg       <= minute_next;
            sec_reg          <= sec_next;
            weekday_reg      <= weekday_next;
            oor_reg          <= oor_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign year         = year_reg;
    assign month_index  = month_reg;
    assign day_of_month = dom_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign sec          = sec_reg;
    assign weekday      = weekday_reg;
    assign out_of_range = oor_reg;

    // a result strobe always lands with the sequencer back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while sequencer busy");

    // an accepted transaction keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not start the sequencer");

    // month walk never passes Esfand
    assert property (@(posedge clk) disable iff (!rst_n) mon_reg <= 4'd11)
        else $error("month index past Esfand");

    // year walk stops one past the table limit
    assert property (@(posedge clk) disable iff (!rst_n) yr_reg <= YEAR_LIMIT + 11'd1)
        else $error("year walk ran past the table");

    // out of range results carry zero date fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> (year == '0 && month_index == '0 && day_of_month == '0))
        else $error("out of range result with nonzero date");

endmodule
